@@ src/wrlk_pkg.sv @@
// Shared types and constants for the write record ring with offset lookup.
package wrlk_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int ACTION_W   = 2;
    localparam int HANDLE_W   = 32;
    localparam int IN_SIZE_W  = 16;
    localparam int POS_W      = 20;
    localparam int OUT_SIZE_W = 16;
    localparam int OFS_W      = 16;
    localparam int SLOT_W     = 4;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_WALK
    } state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic             evict;
        logic             cont;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

    // Running byte count handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] acc;
    } link_t;

    // Cell report; all zero unless the cell holds the reporting token
    typedef struct packed {
        logic                  report;
        logic                  hit;
        logic [HANDLE_W-1:0]   handle;
        logic [OUT_SIZE_W-1:0] size;
        logic [OFS_W-1:0]      offset;
    } report_t;

endpackage

@@ src/write_record_ring_with_offset_lookup_core.sv @@
// Write record ring with byte offset lookup: controller and ring of slot cells.
// Add to a ring that is not full, find on an empty ring, clear and unused actions: result in the cycle after transfer.
// Add to a full ring: an eviction token goes to the write slot and, in ST_EVICT, reads the slot before it is rewritten.
// Find: the token walks the stored slots from the oldest, one cell per cycle, through up to DEPTH slots.
// One item in flight at a time; a new item is taken once the result register is free.
// Reset (async, active low) empties the ring; record contents are not cleared.
module write_record_ring_with_offset_lookup_core #(
    parameter int DEPTH      = wrlk_pkg::DEPTH_DEF,
    parameter int SIZE_WIDTH = wrlk_pkg::SIZE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wrlk_pkg::ACTION_W-1:0]   action,
    input  logic [wrlk_pkg::HANDLE_W-1:0]   record_handle,
    input  logic [wrlk_pkg::IN_SIZE_W-1:0]  record_size,
    input  logic [wrlk_pkg::POS_W-1:0]      byte_position,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic                            evicted,
    output logic [wrlk_pkg::HANDLE_W-1:0]   out_handle,
    output logic [wrlk_pkg::OUT_SIZE_W-1:0] out_size,
    output logic [wrlk_pkg::OFS_W-1:0]      offset_within,
    output logic [wrlk_pkg::SLOT_W-1:0]     slot_number
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [31:0] SIZE_MAX = (32'd1 << SIZE_WIDTH) - 32'd1;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        next_slot = (s == IDX_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    wrlk_pkg::state_t state_reg;
    wrlk_pkg::state_t state_next;

    logic [IDX_W-1:0] wi_reg;
    logic [IDX_W-1:0] wi_next;
    logic [IDX_W-1:0] ri_reg;
    logic [IDX_W-1:0] ri_next;
    logic             full_reg;
    logic             full_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] walk_slot_reg;
    logic [IDX_W-1:0] walk_slot_next;

    logic [wrlk_pkg::HANDLE_W-1:0] handle_hold_reg;
    logic [SIZE_WIDTH-1:0]         size_hold_reg;
    logic [wrlk_pkg::POS_W-1:0]    pos_reg;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            hit_reg;
    logic                            evicted_reg;
    logic [wrlk_pkg::HANDLE_W-1:0]   handle_reg;
    logic [wrlk_pkg::OUT_SIZE_W-1:0] size_reg;
    logic [wrlk_pkg::OFS_W-1:0]      offset_reg;
    logic [wrlk_pkg::SLOT_W-1:0]     slot_reg;

    logic                  in_fire;
    logic                  is_add;
    logic                  is_find;
    logic                  is_clear;
    logic [IDX_W:0]        used_diff;
    logic [CNT_W-1:0]      count_now;
    logic [31:0]           size_in_wide;
    logic [SIZE_WIDTH-1:0] size_sat;

    logic                            inject;
    logic [IDX_W-1:0]                inject_slot;
    logic                            wr_en;
    logic [wrlk_pkg::HANDLE_W-1:0]   wr_handle;
    logic [SIZE_WIDTH-1:0]           wr_size;
    logic                            add_done;
    logic                            add_evict;
    logic                            res_load;
    logic                            res_hit;
    logic                            res_evicted;
    logic [wrlk_pkg::HANDLE_W-1:0]   res_handle;
    logic [wrlk_pkg::OUT_SIZE_W-1:0] res_size;
    logic [wrlk_pkg::OFS_W-1:0]      res_offset;
    logic [IDX_W-1:0]                res_slot;
    logic [31:0]                     res_slot_wide;

    wrlk_pkg::cell_ctrl_t ctrl;
    wrlk_pkg::link_t      link [DEPTH];
    wrlk_pkg::report_t    cell_rep [DEPTH];
    wrlk_pkg::report_t    rep;
    logic [DEPTH-1:0]     cell_inject;
    logic [DEPTH-1:0]     cell_wr;

    assign in_ready = (state_reg == wrlk_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign is_add   = (action == wrlk_pkg::ACT_ADD);
    assign is_find  = (action == wrlk_pkg::ACT_FIND);
    assign is_clear = (action == wrlk_pkg::ACT_CLEAR);

    assign size_in_wide = 32'(record_size);
    assign size_sat = (size_in_wide > SIZE_MAX) ? SIZE_MAX[SIZE_WIDTH-1:0]
                                                : size_in_wide[SIZE_WIDTH-1:0];

    assign used_diff = (wi_reg >= ri_reg) ? ({1'b0, wi_reg} - {1'b0, ri_reg})
                                          : ({1'b0, wi_reg} + (IDX_W + 1)'(DEPTH)
                                             - {1'b0, ri_reg});
    assign count_now = full_reg ? CNT_W'(DEPTH) : CNT_W'(used_diff);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrlk_pkg::ST_IDLE:
            begin
                if (in_fire && is_add && full_reg)
                    state_next = wrlk_pkg::ST_EVICT;
                else if (in_fire && is_find && (count_now != '0))
                    state_next = wrlk_pkg::ST_WALK;
            end
            wrlk_pkg::ST_EVICT:
                state_next = wrlk_pkg::ST_IDLE;
            wrlk_pkg::ST_WALK:
            begin
                if (rep.report || (cnt_reg == CNT_W'(1)))
                    state_next = wrlk_pkg::ST_IDLE;
            end
            default:
                state_next = wrlk_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        inject      = 1'b0;
        inject_slot = ri_reg;
        ctrl.evict  = 1'b0;
        ctrl.cont   = 1'b0;
        ctrl.pos    = pos_reg;
        wr_en       = 1'b0;
        wr_handle   = record_handle;
        wr_size     = size_sat;
        add_done    = 1'b0;
        add_evict   = 1'b0;
        res_load    = 1'b0;
        res_hit     = 1'b0;
        res_evicted = 1'b0;
        res_handle  = '0;
        res_size    = '0;
        res_offset  = '0;
        res_slot    = '0;
        unique case (state_reg)
            wrlk_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_add && full_reg)
                    begin
                        inject      = 1'b1;
                        inject_slot = wi_reg;
                        ctrl.evict  = 1'b1;
                    end
                    else if (is_find && (count_now != '0))
                    begin
                        inject      = 1'b1;
                        inject_slot = ri_reg;
                    end
                    else
                    begin
                        res_load = 1'b1;
                        if (is_add)
                        begin
                            wr_en    = 1'b1;
                            add_done = 1'b1;
                        end
                    end
                end
            end
            wrlk_pkg::ST_EVICT:
            begin
                // Old contents are shown this cycle and overwritten at the edge
                wr_en       = 1'b1;
                wr_handle   = handle_hold_reg;
                wr_size     = size_hold_reg;
                add_done    = 1'b1;
                add_evict   = 1'b1;
                res_load    = 1'b1;
                res_evicted = 1'b1;
                res_handle  = rep.handle;
                res_size    = rep.size;
                res_slot    = wi_reg;
            end
            wrlk_pkg::ST_WALK:
            begin
                ctrl.cont = (cnt_reg != CNT_W'(1));
                if (rep.report)
                begin
                    res_load   = 1'b1;
                    res_hit    = rep.hit;
                    res_handle = rep.handle;
                    res_size   = rep.size;
                    res_offset = rep.offset;
                    res_slot   = walk_slot_reg;
                end
                else if (cnt_reg == CNT_W'(1))
                    res_load = 1'b1;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Ring indices
    always_comb
    begin
        wi_next   = wi_reg;
        ri_next   = ri_reg;
        full_next = full_reg;
        if (add_done)
        begin
            wi_next = next_slot(wi_reg);
            if (add_evict)
                ri_next = next_slot(ri_reg);
            full_next = (next_slot(wi_reg) == ri_next);
        end
        else if (in_fire && is_clear)
        begin
            wi_next   = '0;
            ri_next   = '0;
            full_next = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        walk_slot_next = walk_slot_reg;
        if (inject)
        begin
            cnt_next       = count_now;
            walk_slot_next = inject_slot;
        end
        else if (state_reg == wrlk_pkg::ST_WALK)
        begin
            cnt_next       = cnt_reg - 1'b1;
            walk_slot_next = next_slot(walk_slot_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrlk_pkg::ST_IDLE;
            wi_reg        <= '0;
            ri_reg        <= '0;
            full_reg      <= 1'b0;
            cnt_reg       <= '0;
            walk_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wi_reg        <= wi_next;
            ri_reg        <= ri_next;
            full_reg      <= full_next;
            cnt_reg       <= cnt_next;
            walk_slot_reg <= walk_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            handle_hold_reg <= record_handle;
            size_hold_reg   <= size_sat;
            pos_reg         <= byte_position;
        end
    end

    assign res_slot_wide = 32'(res_slot);

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            hit_reg     <= res_hit;
            evicted_reg <= res_evicted;
            handle_reg  <= res_handle;
            size_reg    <= res_size;
            offset_reg  <= res_offset;
            slot_reg    <= res_slot_wide[wrlk_pkg::SLOT_W-1:0];
        end
    end

    // Ring of cells; the walk token moves one cell per cycle
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign cell_inject[g] = inject && (inject_slot == IDX_W'(g));
            assign cell_wr[g]     = wr_en && (wi_reg == IDX_W'(g));

            wrlk_cell #(
                .SIZE_WIDTH (SIZE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .inject    (cell_inject[g]),
                .wr_en     (cell_wr[g]),
                .wr_handle (wr_handle),
                .wr_size   (wr_size),
                .link_in   (link[(g + DEPTH - 1) % DEPTH]),
                .link_out  (link[g]),
                .rep       (cell_rep[g])
            );
        end
    endgenerate

    // At most one cell holds the token, so the reports merge by OR
    always_comb
    begin
        rep = '0;
        for (int i = 0; i < DEPTH; i++)
            rep = rep | cell_rep[i];
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted       = evicted_reg;
    assign out_handle    = handle_reg;
    assign out_size      = size_reg;
    assign offset_within = offset_reg;
    assign slot_number   = slot_reg;

endmodule

@@ src/wrlk_cell.sv @@
// One ring slot: stores a record and tests the walk token against its byte range.
module wrlk_cell #(
    parameter int SIZE_WIDTH = wrlk_pkg::SIZE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wrlk_pkg::cell_ctrl_t          ctrl,
    input  logic                          inject,
    input  logic                          wr_en,
    input  logic [wrlk_pkg::HANDLE_W-1:0] wr_handle,
    input  logic [SIZE_WIDTH-1:0]         wr_size,
    input  wrlk_pkg::link_t               link_in,
    output wrlk_pkg::link_t               link_out,
    output wrlk_pkg::report_t             rep
);

    localparam int SUM_W = ((SIZE_WIDTH > wrlk_pkg::POS_W) ? SIZE_WIDTH : wrlk_pkg::POS_W) + 1;

    logic [wrlk_pkg::HANDLE_W-1:0] handle_reg;
    logic [SIZE_WIDTH-1:0]         size_reg;
    logic                          tok_valid_reg;
    logic                          tok_valid_next;
    logic                          tok_evict_reg;
    logic                          tok_evict_next;
    logic [wrlk_pkg::POS_W-1:0]    tok_acc_reg;
    logic [wrlk_pkg::POS_W-1:0]    tok_acc_next;

    logic [SUM_W-1:0]           sum;
    logic                       hit_here;
    logic [SUM_W-1:0]           size_wide;
    logic [wrlk_pkg::POS_W-1:0] ofs_wide;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            handle_reg <= wr_handle;
            size_reg   <= wr_size;
        end
    end

    always_comb
    begin
        if (inject)
        begin
            tok_valid_next = 1'b1;
            tok_evict_next = ctrl.evict;
            tok_acc_next   = '0;
        end
        else
        begin
            tok_valid_next = link_in.valid & ctrl.cont;
            tok_evict_next = 1'b0;
            tok_acc_next   = link_in.acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_valid_next;
    end

    always_ff @(posedge clk)
    begin
        tok_evict_reg <= tok_evict_next;
        tok_acc_reg   <= tok_acc_next;
    end

    assign size_wide = SUM_W'(size_reg);
    assign sum       = SUM_W'(tok_acc_reg) + size_wide;
    assign hit_here  = sum > SUM_W'(ctrl.pos);
    assign ofs_wide  = ctrl.pos - tok_acc_reg;

    // A passed count never exceeds the position, so it fits the position width
    assign link_out.valid = tok_valid_reg & ~tok_evict_reg & ~hit_here;
    assign link_out.acc   = sum[wrlk_pkg::POS_W-1:0];

    always_comb
    begin
        rep = '0;
        if (tok_valid_reg && (tok_evict_reg || hit_here))
        begin
            rep.report = 1'b1;
            rep.hit    = ~tok_evict_reg;
            rep.handle = handle_reg;
            rep.size   = size_wide[wrlk_pkg::OUT_SIZE_W-1:0];
            rep.offset = ofs_wide[wrlk_pkg::OFS_W-1:0];
        end
    end

endmodule
